@@ src/cbcrc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbcrc_pkg - shared types, constants and bit step for the CRC core
// Register indexes, reset values, control struct and the single-bit update.
// ----------------------------------------------------------------------------
package cbcrc_pkg;

    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_IDX_BITS  = 3;
    localparam int WIDTH_BITS    = 7;
    localparam int WORD_BITS     = 64;

    typedef logic [WORD_BITS-1:0]     t_word;
    typedef logic [WIDTH_BITS-1:0]    t_width;
    typedef logic [CFG_IDX_BITS-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_BITS-1:0] t_cfg_data;

    // register indexes on the config port
    localparam t_cfg_idx REG_CRC_WIDTH     = 3'd0;
    localparam t_cfg_idx REG_POLYNOMIAL    = 3'd1;
    localparam t_cfg_idx REG_INITIAL_VALUE = 3'd2;
    localparam t_cfg_idx REG_FINAL_XOR     = 3'd3;
    localparam t_cfg_idx REG_REFLECTED     = 3'd4;
    localparam t_cfg_idx REG_AUGMENTED     = 3'd5;

    localparam t_width RST_CRC_WIDTH     = 7'd16;
    localparam t_word  RST_POLYNOMIAL    = 64'h0000_0000_0000_1021;
    localparam t_word  RST_INITIAL_VALUE = 64'h0;
    localparam t_word  RST_FINAL_XOR     = 64'h0;
    localparam logic   RST_REFLECTED     = 1'b0;
    localparam logic   RST_AUGMENTED     = 1'b0;

    typedef struct packed {
        logic   refl;
        logic   aug;
        t_width width;   // effective width, already clamped
    } t_ctl;

    // One register shift with message bit b; returns r unchanged when en is low.
    function automatic t_word crc_bit(
        input t_word r,
        input logic  b,
        input logic  en,
        input t_word mask,
        input t_word top,
        input t_word poly,
        input logic  refl,
        input logic  aug
    );
        t_word v;
        logic  out;
        logic  fb;
        v = r;
        if (refl) begin
            out = r[0];
            v   = r >> 1;
            if (aug && b) begin
                v = v | top;
            end
        end else begin
            out = |(r & top);
            v   = (r << 1) & mask;
            if (aug && b) begin
                v = v | t_word'(1);
            end
        end
        fb = aug ? out : (out ^ b);
        if (fb) begin
            v = v ^ poly;
        end
        v = v & mask;
        return en ? v : r;
    endfunction

endpackage
`default_nettype wire

@@ src/configurable_bitwise_crc_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// configurable_bitwise_crc_core - configurable bit-serial CRC, byte per beat
// Width 1..MAX_CRC_WIDTH, polynomial, init, final XOR, reflect, augment.
// ----------------------------------------------------------------------------
// Takes one message byte per clock while o_stall is low (0 to 8 valid bits
// each) and returns one CRC per message on the beat marked last. The byte
// update is eight masked bit steps done combinationally; the augmented zero
// flush runs in a pipeline of ceil(MAX_CRC_WIDTH/8) stages, eight bits each,
// and non-augmented results ride through the same stages. A result passes
// through the flush stages into the output register, and new bytes are
// taken while results wait there unless back-pressure reaches the input.
// Configuration may only be written while the core is idle.
// ----------------------------------------------------------------------------
module configurable_bitwise_crc_core
    import cbcrc_pkg::*;
#(
    parameter int MAX_CRC_WIDTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire t_cfg_idx    i_cfg_index,
    input  wire t_cfg_data   i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [3:0]  i_bit_count,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_crc_value
);

    localparam int W  = MAX_CRC_WIDTH;
    localparam int NF = (MAX_CRC_WIDTH + 7) / 8;

    t_ctl          ctl;
    logic [W-1:0]  cfg_mask;
    logic [W-1:0]  cfg_top;
    logic [W-1:0]  cfg_poly;
    logic [W-1:0]  cfg_init;
    logic [W-1:0]  cfg_fxor;

    logic          f_valid [0:NF];
    logic          f_stall [0:NF];
    logic [W-1:0]  f_crc   [0:NF];

    logic          r_out_valid;
    logic [63:0]   r_out_crc;
    logic          out_load;

    cbcrc_cfg #(
        .W (W)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_ctl       (ctl),
        .o_mask      (cfg_mask),
        .o_top       (cfg_top),
        .o_poly      (cfg_poly),
        .o_init      (cfg_init),
        .o_fxor      (cfg_fxor)
    );

    cbcrc_byte #(
        .W (W)
    ) u_byte (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_bit_count (i_bit_count),
        .i_last_byte (i_last_byte),
        .i_ctl       (ctl),
        .i_mask      (cfg_mask),
        .i_top       (cfg_top),
        .i_poly      (cfg_poly),
        .i_init      (cfg_init),
        .o_valid     (f_valid[0]),
        .i_stall     (f_stall[0]),
        .o_crc       (f_crc[0])
    );

    for (genvar k = 0; k < NF; k++) begin : g_flush
        cbcrc_flush #(
            .W     (W),
            .STAGE (k)
        ) u_flush (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_mask  (cfg_mask),
            .i_top   (cfg_top),
            .i_poly  (cfg_poly),
            .i_valid (f_valid[k]),
            .o_stall (f_stall[k]),
            .i_crc   (f_crc[k]),
            .o_valid (f_valid[k+1]),
            .i_stall (f_stall[k+1]),
            .o_crc   (f_crc[k+1])
        );
    end

    // output register: final XOR and width mask
    assign f_stall[NF] = r_out_valid && i_stall;
    assign out_load    = f_valid[NF] && !f_stall[NF];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_crc <= 64'((f_crc[NF] ^ cfg_fxor) & cfg_mask);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_crc_value = r_out_crc;

endmodule
`default_nettype wire

@@ src/cbcrc_cfg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbcrc_cfg - configuration registers
// Holds the written registers and the derived width, mask, top bit and
// (possibly reversed) polynomial, all updated on the write edge itself.
// ----------------------------------------------------------------------------
module cbcrc_cfg
    import cbcrc_pkg::*;
#(
    parameter int W = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_wr_en,
    input  wire t_cfg_idx     i_cfg_index,
    input  wire t_cfg_data    i_cfg_wdata,
    output t_ctl              o_ctl,
    output logic [W-1:0]      o_mask,
    output logic [W-1:0]      o_top,
    output logic [W-1:0]      o_poly,
    output logic [W-1:0]      o_init,
    output logic [W-1:0]      o_fxor
);

    localparam t_width W_BITS = t_width'(W);

    // raw registers
    t_width        r_crc_width, n_crc_width;
    logic [W-1:0]  r_poly_raw,  n_poly_raw;
    logic [W-1:0]  r_init_raw,  n_init_raw;
    logic [W-1:0]  r_fxor_raw,  n_fxor_raw;
    logic          r_refl,      n_refl;
    logic          r_aug,       n_aug;

    // derived registers
    t_width        r_width;
    logic [W-1:0]  r_mask;
    logic [W-1:0]  r_top;
    logic [W-1:0]  r_poly;
    logic [W-1:0]  r_init;
    logic [W-1:0]  r_fxor;

    t_width        rst_w, n_w;
    logic [W-1:0]  rst_mask, n_mask;

    function automatic t_width eff_width(input t_width raw);
        t_width w;
        w = raw;
        if (raw == '0) begin
            w = 7'd1;
        end else if (raw > W_BITS) begin
            w = W_BITS;
        end
        return w;
    endfunction

    function automatic logic [W-1:0] mask_of(input t_width w);
        return {W{1'b1}} >> (W_BITS - w);
    endfunction

    function automatic logic [W-1:0] top_of(input t_width w);
        return W'(1) << (w - 7'd1);
    endfunction

    // reversal over the width: full reverse, then drop the unused low part
    function automatic logic [W-1:0] poly_of(
        input logic [W-1:0] p,
        input logic [W-1:0] mask,
        input t_width       w,
        input logic         refl
    );
        logic [W-1:0] pm;
        logic [W-1:0] rev;
        pm = p & mask;
        for (int i = 0; i < W; i++) begin
            rev[i] = pm[W-1-i];
        end
        return refl ? (rev >> (W_BITS - w)) : pm;
    endfunction

    always_comb begin
        n_crc_width = r_crc_width;
        n_poly_raw  = r_poly_raw;
        n_init_raw  = r_init_raw;
        n_fxor_raw  = r_fxor_raw;
        n_refl      = r_refl;
        n_aug       = r_aug;
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_CRC_WIDTH:     n_crc_width = i_cfg_wdata[WIDTH_BITS-1:0];
                REG_POLYNOMIAL:    n_poly_raw  = i_cfg_wdata[W-1:0];
                REG_INITIAL_VALUE: n_init_raw  = i_cfg_wdata[W-1:0];
                REG_FINAL_XOR:     n_fxor_raw  = i_cfg_wdata[W-1:0];
                REG_REFLECTED:     n_refl      = i_cfg_wdata[0];
                REG_AUGMENTED:     n_aug       = i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign rst_w    = eff_width(RST_CRC_WIDTH);
    assign rst_mask = mask_of(rst_w);
    assign n_w      = eff_width(n_crc_width);
    assign n_mask   = mask_of(n_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_width <= RST_CRC_WIDTH;
            r_poly_raw  <= RST_POLYNOMIAL[W-1:0];
            r_init_raw  <= RST_INITIAL_VALUE[W-1:0];
            r_fxor_raw  <= RST_FINAL_XOR[W-1:0];
            r_refl      <= RST_REFLECTED;
            r_aug       <= RST_AUGMENTED;
            r_width     <= rst_w;
            r_mask      <= rst_mask;
            r_top       <= top_of(rst_w);
            r_poly      <= poly_of(RST_POLYNOMIAL[W-1:0], rst_mask, rst_w, RST_REFLECTED);
            r_init      <= RST_INITIAL_VALUE[W-1:0] & rst_mask;
            r_fxor      <= RST_FINAL_XOR[W-1:0] & rst_mask;
        end else begin
            r_crc_width <= n_crc_width;
            r_poly_raw  <= n_poly_raw;
            r_init_raw  <= n_init_raw;
            r_fxor_raw  <= n_fxor_raw;
            r_refl      <= n_refl;
            r_aug       <= n_aug;
            r_width     <= n_w;
            r_mask      <= n_mask;
            r_top       <= top_of(n_w);
            r_poly      <= poly_of(n_poly_raw, n_mask, n_w, n_refl);
            r_init      <= n_init_raw & n_mask;
            r_fxor      <= n_fxor_raw & n_mask;
        end
    end

    assign o_ctl.refl  = r_refl;
    assign o_ctl.aug   = r_aug;
    assign o_ctl.width = r_width;
    assign o_mask      = r_mask;
    assign o_top       = r_top;
    assign o_poly      = r_poly;
    assign o_init      = r_init;
    assign o_fxor      = r_fxor;

endmodule
`default_nettype wire

@@ src/cbcrc_byte.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbcrc_byte - input register and per-byte CRC update
// Runs up to eight masked bit steps per beat on the running register and
// hands the register of the last beat of a message to the flush pipeline.
// ----------------------------------------------------------------------------
module cbcrc_byte
    import cbcrc_pkg::*;
#(
    parameter int W = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic [7:0]   i_data_byte,
    input  wire logic [3:0]   i_bit_count,
    input  wire logic         i_last_byte,
    input  wire t_ctl         i_ctl,
    input  wire logic [W-1:0] i_mask,
    input  wire logic [W-1:0] i_top,
    input  wire logic [W-1:0] i_poly,
    input  wire logic [W-1:0] i_init,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic [W-1:0]      o_crc
);

    logic          r_valid;
    logic [7:0]    r_data;
    logic [3:0]    r_count;
    logic          r_last;
    logic [W-1:0]  r_crc;
    logic          r_start;

    logic          fire;
    logic          accept;
    logic [3:0]    cnt;
    t_word         acc;

    // non-last beats retire here; only the last one needs the next stage
    assign fire    = r_valid && (!r_last || !i_stall);
    assign o_stall = r_valid && !fire;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        cnt = (r_count > 4'd8) ? 4'd8 : r_count;
        acc = t_word'((r_start ? i_init : r_crc) & i_mask);
        for (int i = 0; i < 8; i++) begin
            acc = crc_bit(acc,
                          i_ctl.refl ? r_data[3'(i)] : r_data[3'(7 - i)],
                          (4'(i) < cnt),
                          t_word'(i_mask), t_word'(i_top), t_word'(i_poly),
                          i_ctl.refl, i_ctl.aug);
        end
    end

    assign o_valid = r_valid && r_last;
    assign o_crc   = acc[W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_start <= 1'b1;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
            end else if (fire) begin
                r_valid <= 1'b0;
            end
            if (fire) begin
                r_start <= r_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data  <= i_data_byte;
            r_count <= i_bit_count;
            r_last  <= i_last_byte;
        end
        if (fire && !r_last) begin
            r_crc <= acc[W-1:0];
        end
    end

endmodule
`default_nettype wire

@@ src/cbcrc_flush.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbcrc_flush - one stage of the zero-bit flush pipeline
// Shifts up to eight zero bits (of the width's worth) per stage in augmented mode;
// otherwise the value passes through unchanged.
// ----------------------------------------------------------------------------
module cbcrc_flush
    import cbcrc_pkg::*;
#(
    parameter int W     = 64,
    parameter int STAGE = 0
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_ctl         i_ctl,
    input  wire logic [W-1:0] i_mask,
    input  wire logic [W-1:0] i_top,
    input  wire logic [W-1:0] i_poly,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic [W-1:0] i_crc,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic [W-1:0]      o_crc
);

    logic          r_valid;
    logic [W-1:0]  r_crc;
    logic          load;
    t_word         acc;

    assign o_stall = r_valid && i_stall;
    assign load    = i_valid && !o_stall;

    always_comb begin
        acc = t_word'(i_crc);
        for (int j = 0; j < 8; j++) begin
            acc = crc_bit(acc, 1'b0,
                          i_ctl.aug && (t_width'(STAGE * 8 + j) < i_ctl.width),
                          t_word'(i_mask), t_word'(i_top), t_word'(i_poly),
                          i_ctl.refl, i_ctl.aug);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_crc <= acc[W-1:0];
        end
    end

    assign o_valid = r_valid;
    assign o_crc   = r_crc;

endmodule
`default_nettype wire
